[rtl/core/tapr_pkg.sv]
// ----------------------------------------------------------------------------
// tapr_pkg
// Shared types, constants and tables for the three axis point rotation.
// ----------------------------------------------------------------------------
package tapr_pkg;

    localparam int COORD_WIDTH  = 32;
    localparam int ANGLE_BITS   = 16;
    localparam int CORDIC_STEPS = 28;
    localparam int TRIG_W       = 16;
    localparam int TRIG_FRAC    = 14;
    localparam int CORDIC_W     = 34;
    localparam int ZACC_W       = 33;
    localparam int CFG_IDX_W    = 3;

    localparam logic [CFG_IDX_W-1:0] REG_PIVOT_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PIVOT_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PIVOT_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ANG_X   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ANG_Y   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ANG_Z   = 3'd5;

    // gain-compensated 1.0 in Q4.30
    localparam logic signed [CORDIC_W-1:0] CORDIC_X0 = 34'sd652032874;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] in_x;
        logic signed [COORD_WIDTH-1:0] in_y;
        logic signed [COORD_WIDTH-1:0] in_z;
    } t_in_item;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] out_x;
        logic signed [COORD_WIDTH-1:0] out_y;
        logic signed [COORD_WIDTH-1:0] out_z;
    } t_out_item;

    typedef struct packed {
        logic mul;
        logic sum;
    } t_rot_en;

    // arctangent in 2^-32 turn units
    function automatic logic signed [ZACC_W-1:0] atan_turns(input logic [4:0] idx);
        logic signed [ZACC_W-1:0] r;
        case (idx)
            5'd0:  r = 33'sd536870912;
            5'd1:  r = 33'sd316933406;
            5'd2:  r = 33'sd167458907;
            5'd3:  r = 33'sd85004756;
            5'd4:  r = 33'sd42667332;
            5'd5:  r = 33'sd21354465;
            5'd6:  r = 33'sd10679838;
            5'd7:  r = 33'sd5340245;
            5'd8:  r = 33'sd2670163;
            5'd9:  r = 33'sd1335087;
            5'd10: r = 33'sd667544;
            5'd11: r = 33'sd333772;
            5'd12: r = 33'sd166886;
            5'd13: r = 33'sd83443;
            5'd14: r = 33'sd41722;
            5'd15: r = 33'sd20861;
            5'd16: r = 33'sd10430;
            5'd17: r = 33'sd5215;
            5'd18: r = 33'sd2608;
            5'd19: r = 33'sd1304;
            5'd20: r = 33'sd652;
            5'd21: r = 33'sd326;
            5'd22: r = 33'sd163;
            5'd23: r = 33'sd81;
            5'd24: r = 33'sd41;
            5'd25: r = 33'sd20;
            5'd26: r = 33'sd10;
            5'd27: r = 33'sd5;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

[rtl/core/tapr_rot.sv]
// ----------------------------------------------------------------------------
// tapr_rot
// One plane rotation, two stages: products, then round, shift and saturate.
// ----------------------------------------------------------------------------
module tapr_rot (
    input  logic                                  i_clk,
    input  tapr_pkg::t_rot_en                     i_en,
    input  logic signed [tapr_pkg::COORD_WIDTH-1:0] i_a,
    input  logic signed [tapr_pkg::COORD_WIDTH-1:0] i_b,
    input  logic signed [tapr_pkg::COORD_WIDTH-1:0] i_pass,
    input  logic signed [tapr_pkg::TRIG_W-1:0]      i_sin,
    input  logic signed [tapr_pkg::TRIG_W-1:0]      i_cos,
    output logic signed [tapr_pkg::COORD_WIDTH-1:0] o_a,
    output logic signed [tapr_pkg::COORD_WIDTH-1:0] o_b,
    output logic signed [tapr_pkg::COORD_WIDTH-1:0] o_pass
);
    localparam int CW = tapr_pkg::COORD_WIDTH;
    localparam int PW = CW + tapr_pkg::TRIG_W;
    localparam int SW = PW + 1;
    localparam logic signed [SW-1:0] RND = SW'(1) <<< (tapr_pkg::TRIG_FRAC - 1);

    logic signed [PW-1:0] r_ac, r_bs, r_as, r_bc;
    logic signed [CW-1:0] r_pm, r_a, r_b, r_p;
    logic signed [SW-1:0] sum_a, sum_b, sh_a, sh_b;

    function automatic logic signed [CW-1:0] sat(input logic signed [SW-1:0] v);
        logic signed [CW-1:0] r;
        if (&v[SW-1:CW-1] || ~|v[SW-1:CW-1]) begin
            r = v[CW-1:0];
        end else begin
            r = v[SW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
        end
        return r;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_en.mul) begin
            r_ac <= i_a * i_cos;
            r_bs <= i_b * i_sin;
            r_as <= i_a * i_sin;
            r_bc <= i_b * i_cos;
            r_pm <= i_pass;
        end
    end

    always_comb begin
        sum_a = SW'(r_ac) - SW'(r_bs) + RND;
        sum_b = SW'(r_as) + SW'(r_bc) + RND;
        sh_a  = sum_a >>> tapr_pkg::TRIG_FRAC;
        sh_b  = sum_b >>> tapr_pkg::TRIG_FRAC;
    end

    always_ff @(posedge i_clk) begin
        if (i_en.sum) begin
            r_a <= sat(sh_a);
            r_b <= sat(sh_b);
            r_p <= r_pm;
        end
    end

    assign o_a    = r_a;
    assign o_b    = r_b;
    assign o_pass = r_p;
endmodule

[rtl/core/three_axis_point_rotation.sv]
// ----------------------------------------------------------------------------
// three_axis_point_rotation
// Rotates points about a pivot, X then Y then Z, Q16.16 with saturation.
// ----------------------------------------------------------------------------
// One point per cycle sustained while the output is not stalled and no
// recompute is running. Accepted requests pass through subtract, two stages
// per axis rotation and add back. Sine and cosine are held in registers and
// made by a CORDIC sequencer doing one iteration per cycle; after reset and
// every angle write, o_ready stays low while it redoes all three angles.
module three_axis_point_rotation #(
    parameter int ANGLE_BITS = tapr_pkg::ANGLE_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  tapr_pkg::t_in_item                  i_data,
    output logic                                o_valid,
    input  logic                                i_ready,
    output tapr_pkg::t_out_item                 o_data,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [tapr_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [tapr_pkg::COORD_WIDTH-1:0]    i_cfg_data
);
    localparam int CW = tapr_pkg::COORD_WIDTH;
    localparam int NS = 8;
    localparam int KW = tapr_pkg::CORDIC_W;
    localparam int ZW = tapr_pkg::ZACC_W;
    localparam int TW = tapr_pkg::TRIG_W;
    localparam logic [4:0] LAST_IT = 5'(tapr_pkg::CORDIC_STEPS - 1);
    localparam logic signed [TW-1:0] TRIG_ONE = TW'(1) <<< tapr_pkg::TRIG_FRAC;

    // ---------------- configuration
    logic signed [CW-1:0]  r_piv [3];
    logic [ANGLE_BITS-1:0] r_ang [3];
    logic                  cfg_wr, ang_wr;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr = i_cfg_valid;
    assign ang_wr = cfg_wr && (i_cfg_index == tapr_pkg::REG_ANG_X ||
                               i_cfg_index == tapr_pkg::REG_ANG_Y ||
                               i_cfg_index == tapr_pkg::REG_ANG_Z);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                r_piv[k] <= '0;
                r_ang[k] <= '0;
            end
        end else if (cfg_wr) begin
            case (i_cfg_index)
                tapr_pkg::REG_PIVOT_X: r_piv[0] <= i_cfg_data;
                tapr_pkg::REG_PIVOT_Y: r_piv[1] <= i_cfg_data;
                tapr_pkg::REG_PIVOT_Z: r_piv[2] <= i_cfg_data;
                tapr_pkg::REG_ANG_X:   r_ang[0] <= i_cfg_data[ANGLE_BITS-1:0];
                tapr_pkg::REG_ANG_Y:   r_ang[1] <= i_cfg_data[ANGLE_BITS-1:0];
                tapr_pkg::REG_ANG_Z:   r_ang[2] <= i_cfg_data[ANGLE_BITS-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- CORDIC sequencer
    logic                 r_busy, r_load;
    logic [1:0]           r_tsel;
    logic [4:0]           r_iter;
    logic signed [KW-1:0] r_cx, r_cy, n_cx, n_cy;
    logic signed [ZW-1:0] r_cz, n_cz;
    logic signed [TW-1:0] r_sin [3];
    logic signed [TW-1:0] r_cos [3];
    logic [ANGLE_BITS-1:0] cur_ang;
    logic [1:0]           quad;
    logic signed [KW-1:0] dx, dy, tc_w, ts_w;
    logic signed [TW-1:0] tc, ts, res_s, res_c;

    function automatic logic signed [TW-1:0] to_trig(input logic signed [KW-1:0] w);
        logic signed [TW-1:0] r;
        if (w > KW'(TRIG_ONE)) begin
            r = TRIG_ONE;
        end else if (w < -KW'(TRIG_ONE)) begin
            r = -TRIG_ONE;
        end else begin
            r = w[TW-1:0];
        end
        return r;
    endfunction

    always_comb begin
        cur_ang = r_ang[r_tsel];
        quad    = cur_ang[ANGLE_BITS-1:ANGLE_BITS-2];
        dx      = r_cx >>> r_iter;
        dy      = r_cy >>> r_iter;
        if (!r_cz[ZW-1]) begin
            n_cx = r_cx - dy;
            n_cy = r_cy + dx;
            n_cz = r_cz - tapr_pkg::atan_turns(r_iter);
        end else begin
            n_cx = r_cx + dy;
            n_cy = r_cy - dx;
            n_cz = r_cz + tapr_pkg::atan_turns(r_iter);
        end
        tc_w = (n_cx + KW'(32768)) >>> 16;
        ts_w = (n_cy + KW'(32768)) >>> 16;
        tc   = to_trig(tc_w);
        ts   = to_trig(ts_w);
        case (quad)
            2'd0: begin res_c = tc;  res_s = ts;  end
            2'd1: begin res_c = -ts; res_s = tc;  end
            2'd2: begin res_c = -tc; res_s = -ts; end
            default: begin res_c = ts; res_s = -tc; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_load <= 1'b1;
            r_tsel <= '0;
            r_iter <= '0;
        end else if (ang_wr) begin
            r_busy <= 1'b1;
            r_load <= 1'b1;
            r_tsel <= '0;
        end else if (r_busy) begin
            if (r_load) begin
                r_load <= 1'b0;
                r_iter <= '0;
            end else if (r_iter == LAST_IT) begin
                r_iter <= '0;
                if (r_tsel == 2'd2) begin
                    r_busy <= 1'b0;
                end else begin
                    r_tsel <= r_tsel + 2'd1;
                    r_load <= 1'b1;
                end
            end else begin
                r_iter <= r_iter + 5'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_load) begin
            r_cx <= tapr_pkg::CORDIC_X0;
            r_cy <= '0;
            r_cz <= ZW'({cur_ang[ANGLE_BITS-3:0], {(32-ANGLE_BITS){1'b0}}});
        end else begin
            r_cx <= n_cx;
            r_cy <= n_cy;
            r_cz <= n_cz;
        end
        if (r_busy && !r_load && r_iter == LAST_IT) begin
            r_sin[r_tsel] <= res_s;
            r_cos[r_tsel] <= res_c;
        end
    end

    // ---------------- point pipeline
    logic [NS-1:0] r_v;
    logic [NS:0]   adv;

    always_comb begin
        adv[NS] = i_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            adv[k] = !r_v[k] || adv[k+1];
        end
    end

    assign o_ready = adv[0] && !r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (adv[0]) r_v[0] <= i_valid && o_ready;
            for (int k = 1; k < NS; k++) begin
                if (adv[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    function automatic logic signed [CW-1:0] sat1(input logic signed [CW:0] v);
        logic signed [CW-1:0] r;
        if (v[CW] == v[CW-1]) begin
            r = v[CW-1:0];
        end else begin
            r = v[CW] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
        end
        return r;
    endfunction

    logic signed [CW-1:0] r_lx, r_ly, r_lz;

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_lx <= sat1((CW+1)'(i_data.in_x) - (CW+1)'(r_piv[0]));
            r_ly <= sat1((CW+1)'(i_data.in_y) - (CW+1)'(r_piv[1]));
            r_lz <= sat1((CW+1)'(i_data.in_z) - (CW+1)'(r_piv[2]));
        end
    end

    logic signed [CW-1:0] x1, y1, z1, x2, y2, z2, x3, y3, z3;
    tapr_pkg::t_rot_en en_x, en_y, en_z;

    assign en_x = '{mul: adv[1], sum: adv[2]};
    assign en_y = '{mul: adv[3], sum: adv[4]};
    assign en_z = '{mul: adv[5], sum: adv[6]};

    tapr_rot u_rot_x (
        .i_clk(i_clk), .i_en(en_x), .i_a(r_ly), .i_b(r_lz), .i_pass(r_lx),
        .i_sin(r_sin[0]), .i_cos(r_cos[0]), .o_a(y1), .o_b(z1), .o_pass(x1)
    );

    tapr_rot u_rot_y (
        .i_clk(i_clk), .i_en(en_y), .i_a(x1), .i_b(z1), .i_pass(y1),
        .i_sin(r_sin[1]), .i_cos(r_cos[1]), .o_a(x2), .o_b(z2), .o_pass(y2)
    );

    tapr_rot u_rot_z (
        .i_clk(i_clk), .i_en(en_z), .i_a(x2), .i_b(y2), .i_pass(z2),
        .i_sin(r_sin[2]), .i_cos(r_cos[2]), .o_a(x3), .o_b(y3), .o_pass(z3)
    );

    tapr_pkg::t_out_item r_out;

    always_ff @(posedge i_clk) begin
        if (adv[7]) begin
            r_out.out_x <= sat1((CW+1)'(x3) + (CW+1)'(r_piv[0]));
            r_out.out_y <= sat1((CW+1)'(y3) + (CW+1)'(r_piv[1]));
            r_out.out_z <= sat1((CW+1)'(z3) + (CW+1)'(r_piv[2]));
        end
    end

    assign o_valid = r_v[NS-1];
    assign o_data  = r_out;
endmodule

[bench/tb_three_axis_point_rotation.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_three_axis_point_rotation
// Self-checking bench: drives points through the rotator under changing
// pivots and angles, predicts each rotated point and compares field by field.
// ----------------------------------------------------------------------------
module tb_three_axis_point_rotation;

    localparam int  CW           = tapr_pkg::COORD_WIDTH;
    localparam int  AB           = tapr_pkg::ANGLE_BITS;
    localparam int  IW           = tapr_pkg::CFG_IDX_W;
    localparam int  LIMIT_CYCLES = 400000;
    localparam int  DRAIN_CYCLES = 20;
    localparam logic [IW-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [IW-1:0] REG_SPARE_HI = 3'd7;
    localparam longint COORD_MAX = 64'sd2147483647;
    localparam longint COORD_MIN = -64'sd2147483648;
    localparam longint ATAN_TURNS [tapr_pkg::CORDIC_STEPS] = '{
        536870912, 316933406, 167458907, 85004756, 42667332, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5
    };

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_valid;
    logic                   o_ready;
    tapr_pkg::t_in_item     i_data;
    logic                   o_valid;
    logic                   i_ready;
    tapr_pkg::t_out_item    o_data;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [IW-1:0]          i_cfg_index;
    logic [CW-1:0]          i_cfg_data;

    three_axis_point_rotation u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // mirrored configuration
    logic signed [CW-1:0] pivot [3];
    logic [AB-1:0]        angle [3];

    tapr_pkg::t_out_item rotated_q [$];
    int        errors;
    int        points_sent;
    int        points_checked;
    int        cfg_writes;
    int        cycle_cnt;
    int        send_idle_pct;
    int        recv_stall_pct;
    int        hold_left;

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    function automatic longint sat_coord(input longint v);
        if (v > COORD_MAX) return COORD_MAX;
        if (v < COORD_MIN) return COORD_MIN;
        return v;
    endfunction

    function automatic longint q14_trig(input longint v);
        longint r;
        r = (v + 64'sd32768) >>> 16;
        if (r > 64'sd16384) return 64'sd16384;
        if (r < -64'sd16384) return -64'sd16384;
        return r;
    endfunction

    function automatic void sin_cos(input logic [AB-1:0] ang,
                                    output longint sn, output longint cs);
        logic [31:0] phase;
        longint x, y, z, dx, dy, c, s;
        phase = {ang, {(32 - AB){1'b0}}};
        x = 652032874;
        y = 0;
        z = longint'(phase[29:0]);
        for (int i = 0; i < tapr_pkg::CORDIC_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= ATAN_TURNS[i];
            end else begin
                x += dx; y -= dy; z += ATAN_TURNS[i];
            end
        end
        c = q14_trig(x);
        s = q14_trig(y);
        case (phase[31:30])
            2'd0: begin cs = c;  sn = s;  end
            2'd1: begin cs = -s; sn = c;  end
            2'd2: begin cs = -c; sn = -s; end
            default: begin cs = s; sn = -c; end
        endcase
    endfunction

    function automatic void rotate_pair(inout longint a, inout longint b,
                                        input longint sn, input longint cs);
        longint na, nb;
        na = a * cs - b * sn;
        nb = a * sn + b * cs;
        a = sat_coord((na + 64'sd8192) >>> tapr_pkg::TRIG_FRAC);
        b = sat_coord((nb + 64'sd8192) >>> tapr_pkg::TRIG_FRAC);
    endfunction

    function automatic tapr_pkg::t_out_item rotate_point(input tapr_pkg::t_in_item pt);
        longint    loc [3];
        longint    sx, cx, sy, cy, sz, cz;
        tapr_pkg::t_out_item r;
        loc[0] = sat_coord(longint'(pt.in_x) - longint'(pivot[0]));
        loc[1] = sat_coord(longint'(pt.in_y) - longint'(pivot[1]));
        loc[2] = sat_coord(longint'(pt.in_z) - longint'(pivot[2]));
        sin_cos(angle[0], sx, cx);
        sin_cos(angle[1], sy, cy);
        sin_cos(angle[2], sz, cz);
        rotate_pair(loc[1], loc[2], sx, cx);
        rotate_pair(loc[0], loc[2], sy, cy);
        rotate_pair(loc[0], loc[1], sz, cz);
        r.out_x = CW'(sat_coord(loc[0] + longint'(pivot[0])));
        r.out_y = CW'(sat_coord(loc[1] + longint'(pivot[1])));
        r.out_z = CW'(sat_coord(loc[2] + longint'(pivot[2])));
        return r;
    endfunction

    // ---- receive side ----
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        tapr_pkg::t_out_item exp_pt;
        if (i_rst_n && o_valid && i_ready) begin
            if (rotated_q.size() == 0) begin
                $display("%0t: unexpected result %h", $time, o_data);
                errors++;
            end else begin
                exp_pt = rotated_q.pop_front();
                points_checked++;
                if (o_data.out_x !== exp_pt.out_x) begin
                    $display("%0t: out_x exp %0d got %0d", $time, exp_pt.out_x, o_data.out_x);
                    errors++;
                end
                if (o_data.out_y !== exp_pt.out_y) begin
                    $display("%0t: out_y exp %0d got %0d", $time, exp_pt.out_y, o_data.out_y);
                    errors++;
                end
                if (o_data.out_z !== exp_pt.out_z) begin
                    $display("%0t: out_z exp %0d got %0d", $time, exp_pt.out_z, o_data.out_z);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results pending", cycle_cnt,
                     rotated_q.size());
            $display("tb: failure");
            $finish;
        end
    end

    // ---- send side ----
    task automatic send_point(input tapr_pkg::t_in_item pt);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= pt;
        do @(posedge i_clk); while (!o_ready);
        rotated_q.push_back(rotate_point(pt));
        points_sent++;
    endtask

    task automatic end_burst();
        @(negedge i_clk);
        i_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (rotated_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [IW-1:0] idx,
                             input logic [CW-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            tapr_pkg::REG_PIVOT_X: pivot[0] = val;
            tapr_pkg::REG_PIVOT_Y: pivot[1] = val;
            tapr_pkg::REG_PIVOT_Z: pivot[2] = val;
            tapr_pkg::REG_ANG_X:   angle[0] = val[AB-1:0];
            tapr_pkg::REG_ANG_Y:   angle[1] = val[AB-1:0];
            tapr_pkg::REG_ANG_Z:   angle[2] = val[AB-1:0];
            default: ;
        endcase
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_config(input logic [31:0] px, input logic [31:0] py,
                              input logic [31:0] pz, input logic [31:0] ax,
                              input logic [31:0] ay, input logic [31:0] az);
        wait_drained();
        write_reg(tapr_pkg::REG_PIVOT_X, px);
        write_reg(tapr_pkg::REG_PIVOT_Y, py);
        write_reg(tapr_pkg::REG_PIVOT_Z, pz);
        write_reg(tapr_pkg::REG_ANG_X, ax);
        write_reg(tapr_pkg::REG_ANG_Y, ay);
        write_reg(tapr_pkg::REG_ANG_Z, az);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(5))
            0: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
            1: return 32'($signed($urandom_range(2000000)) - 1000000);
            2: return 32'($signed($urandom_range(200)) - 100) << 16;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] rand_angle();
        case ($urandom_range(4))
            0: return 32'($urandom_range(3)) << 14;
            1: return 32'hffff;
            // high bits above the angle width must be dropped
            2: return $urandom;
            default: return $urandom_range(16'hffff);
        endcase
    endfunction

    function automatic tapr_pkg::t_in_item rand_point();
        tapr_pkg::t_in_item pt;
        pt.in_x = rand_coord();
        pt.in_y = rand_coord();
        pt.in_z = rand_coord();
        return pt;
    endfunction

    function automatic tapr_pkg::t_in_item mk_point(input logic [31:0] x,
                                                    input logic [31:0] y,
                                                    input logic [31:0] z);
        tapr_pkg::t_in_item pt;
        pt.in_x = x;
        pt.in_y = y;
        pt.in_z = z;
        return pt;
    endfunction

    // ---- tests ----
    task automatic test_reset_identity();
        // all-zero config must pass points through
        send_point(mk_point(32'h7fff_ffff, 32'h8000_0000, 32'h0));
        send_point(mk_point(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff));
        send_point(mk_point(32'h0001_0000, 32'hfffe_0000, 32'h0000_0001));
        end_burst();
    endtask

    task automatic test_directed();
        logic [31:0] quarter [5] = '{32'h0, 32'h4000, 32'h8000, 32'hc000, 32'hffff};
        // quadrant corners on each axis
        for (int i = 0; i < 5; i++) begin
            set_config(32'h0, 32'h0, 32'h0, quarter[i], quarter[(i + 1) % 5],
                       quarter[(i + 3) % 5]);
            send_point(mk_point(32'h0003_0000, 32'hfffb_8000, 32'h0001_2345));
            send_point(mk_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000));
            end_burst();
        end
        // pivot far from point: difference and final sum both saturate
        set_config(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                   32'h2000, 32'h6000, 32'h9000);
        send_point(mk_point(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff));
        send_point(mk_point(32'h0, 32'h0, 32'h0));
        send_point(mk_point(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000));
        end_burst();
        // writes to unused indexes change nothing; wide angle data is truncated
        wait_drained();
        write_reg(REG_SPARE_LO, 32'hdead_beef);
        write_reg(REG_SPARE_HI, 32'h1234_5678);
        write_reg(tapr_pkg::REG_ANG_X, 32'habcd_1000);
        send_point(mk_point(32'h0010_0000, 32'hfff0_0000, 32'h0008_0000));
        send_point(mk_point(32'hffff_ffff, 32'h0000_0001, 32'h5555_aaaa));
        end_burst();
    endtask

    task automatic test_random_phase(input int idle_pct, input int stall_pct,
                                     input int n);
        set_config(rand_coord(), rand_coord(), rand_coord(),
                   rand_angle(), rand_angle(), rand_angle());
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < n; i++) begin
            send_point(rand_point());
            // mid-phase pause with every result in before continuing
            if (i == n / 2 && $urandom_range(1)) begin
                end_burst();
                wait_drained();
            end
        end
        end_burst();
    endtask

    task automatic test_backpressure();
        wait_drained();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        @(negedge i_clk);
        hold_left = 200;
        for (int i = 0; i < 60; i++) send_point(rand_point());
        end_burst();
    endtask

    task automatic test_pause_until_drained();
        send_idle_pct  = 0;
        recv_stall_pct = 30;
        for (int i = 0; i < 20; i++) send_point(rand_point());
        end_burst();
        wait_drained();
        for (int i = 0; i < 20; i++) send_point(rand_point());
        end_burst();
    endtask

    initial begin
        int idle_set  [4];
        int stall_set [4];
        idle_set       = '{0, 75, 0, 24};
        stall_set      = '{0, 0, 75, 24};
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_data         = '0;
        i_ready        = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = '0;
        i_cfg_data     = '0;
        errors         = 0;
        points_sent    = 0;
        points_checked = 0;
        cfg_writes     = 0;
        cycle_cnt      = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = 0;
        for (int i = 0; i < 3; i++) begin
            pivot[i] = '0;
            angle[i] = '0;
        end
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_identity();
        test_directed();
        for (int p = 0; p < 20; p++)
            test_random_phase(idle_set[p % 4], stall_set[p % 4], 90);
        test_backpressure();
        test_pause_until_drained();

        wait_drained();
        $display("covered %0d points and %0d register writes over 4 idle mixes,",
                 points_sent, cfg_writes);
        $display("backpressure fill and drained pauses; %0d results checked",
                 points_checked);
        if (errors == 0 && rotated_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

[three_axis_point_rotation.f]
rtl/core/tapr_pkg.sv
rtl/core/tapr_rot.sv
rtl/core/three_axis_point_rotation.sv
bench/tb_three_axis_point_rotation.sv
